>>> sv/rpn_stack_calculator_top_assert.svh
// ----------------------------------------------------------------------------
// RPN calculator assertion macros
// Clocked assertion shorthands, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_TOP_ASSERT_SVH
`define RPN_STACK_CALCULATOR_TOP_ASSERT_SVH

// condition must hold at every edge
`define RPN_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define RPN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rpn_pkg.sv
// ----------------------------------------------------------------------------
// RPN calculator package
// Item types, status codes, character codes and arithmetic unit interface.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

  localparam int STACK_DEPTH_DEF = 128;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_SLASH = 8'd47;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_REJECT = 3'd1,
    ST_OVER   = 3'd2,
    ST_UNDER  = 3'd3,
    ST_DIVZ   = 3'd4,
    ST_HALT   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic       command;
    logic [7:0] character;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] top_value;
    logic [7:0]         depth;
  } out_item_t;

  // result = b op a
  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

endpackage

`default_nettype wire

>>> sv/rpn_alu.sv
// ----------------------------------------------------------------------------
// RPN arithmetic unit
// One shared 33-bit adder, stepped for add, subtract, shift-add multiply
// and restoring signed divide (32 steps plus sign fix).
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_alu (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire rpn_pkg::alu_req_t   req,
  output rpn_pkg::alu_stat_t       stat,
  output logic [31:0]              result
);
  import rpn_pkg::*;

  typedef enum logic [1:0] {A_IDLE, A_RUN, A_FIX} alu_state_t;

  alu_state_t  state_r;
  alu_op_t     op_r;
  logic [32:0] acc_r;
  logic [31:0] q_r;
  logic [31:0] d_r;
  logic [4:0]  cnt_r;
  logic        neg_r;
  logic        done_r;

  logic [32:0] rem_sh;
  logic [32:0] add_x;
  logic [32:0] add_y;
  logic        add_cin;
  logic [33:0] sum;
  logic [31:0] a_mag;
  logic [31:0] b_mag;

  assign rem_sh = {acc_r[31:0], q_r[31]};
  assign a_mag  = req.a[31] ? (~req.a + 32'd1) : req.a;
  assign b_mag  = req.b[31] ? (~req.b + 32'd1) : req.b;

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_cin = 1'b0;
    case (state_r)
      A_RUN: begin
        case (op_r)
          ALU_ADD: begin
            add_x = {1'b0, acc_r[31:0]};
            add_y = {1'b0, d_r};
          end
          ALU_SUB: begin
            add_x   = {1'b0, acc_r[31:0]};
            add_y   = ~{1'b0, d_r};
            add_cin = 1'b1;
          end
          ALU_MUL: begin
            add_x = acc_r;
            add_y = q_r[0] ? {1'b0, d_r} : 33'd0;
          end
          ALU_DIV: begin
            add_x   = rem_sh;
            add_y   = ~{1'b0, d_r};
            add_cin = 1'b1;
          end
          default: ;
        endcase
      end
      A_FIX: begin
        if (neg_r) begin
          add_y   = {1'b0, ~q_r};
          add_cin = 1'b1;
        end else begin
          add_x = {1'b0, q_r};
        end
      end
      default: ;
    endcase
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y} + {33'd0, add_cin};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        A_IDLE: begin
          if (req.start) begin
            op_r    <= req.op;
            cnt_r   <= '0;
            state_r <= A_RUN;
            case (req.op)
              ALU_MUL: begin
                acc_r <= '0;
                d_r   <= req.b;
                q_r   <= req.a;
              end
              ALU_DIV: begin
                acc_r <= '0;
                q_r   <= b_mag;
                d_r   <= a_mag;
                neg_r <= req.a[31] ^ req.b[31];
              end
              default: begin
                acc_r <= {1'b0, req.b};
                d_r   <= req.a;
              end
            endcase
          end
        end
        A_RUN: begin
          case (op_r)
            ALU_MUL: begin
              acc_r <= sum[32:0];
              d_r   <= {d_r[30:0], 1'b0};
              q_r   <= {1'b0, q_r[31:1]};
              cnt_r <= cnt_r + 5'd1;
              if (cnt_r == 5'd31) begin
                done_r  <= 1'b1;
                state_r <= A_IDLE;
              end
            end
            ALU_DIV: begin
              acc_r <= sum[33] ? sum[32:0] : rem_sh;
              q_r   <= {q_r[30:0], sum[33]};
              cnt_r <= cnt_r + 5'd1;
              if (cnt_r == 5'd31) begin
                state_r <= A_FIX;
              end
            end
            default: begin
              acc_r   <= sum[32:0];
              done_r  <= 1'b1;
              state_r <= A_IDLE;
            end
          endcase
        end
        A_FIX: begin
          acc_r   <= sum[32:0];
          done_r  <= 1'b1;
          state_r <= A_IDLE;
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

  assign stat.busy = (state_r != A_IDLE);
  assign stat.done = done_r;
  assign result    = acc_r[31:0];

endmodule

`default_nettype wire

>>> sv/rpn_stack_calculator_top.sv
// RPN stack calculator. Each input item is a clear command or one ASCII
// character; each produces exactly one result item with a status code, the
// value on top of the stack and the stack depth. Clear, digit, halted,
// rejected, underflowing and divide-by-zero items go straight to the output
// state; other +, -, * and / items pass through the execute and wait states
// and the shared arithmetic unit, where * and / take the 32 steps of its
// shift-add / restoring-divide datapath (plus one sign-fix step for /). The
// input is not ready while an item is in progress and is ready again the
// cycle after its result is loaded. A finished result waits in the output
// register; the next item may be accepted meanwhile, but its result waits
// until that register is free.
// ----------------------------------------------------------------------------
// RPN stack calculator top level
// Sequencer, stack memory with cached top entry, and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rpn_stack_calculator_top_assert.svh"

module rpn_stack_calculator_top #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire rpn_pkg::in_item_t   in_item,
  output logic                     out_valid,
  input  wire                      out_ready,
  output rpn_pkg::out_item_t       out_item
);
  import rpn_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAIT, S_OUT} seq_state_t;

  seq_state_t      state_r;
  logic [SPW-1:0]  sp_r;
  logic [31:0]     top_r;
  logic            ovf_r;
  logic            und_r;
  logic            dze_r;
  status_t         status_r;
  alu_op_t         op_r;
  logic            out_valid_r;
  out_item_t       out_item_r;
  logic [31:0]     rd_r;

  logic [31:0]     mem [STACK_DEPTH];

  logic            in_acc;
  logic            is_digit;
  logic            is_op;
  logic            any_flag;
  logic            full;
  logic            push_ok;
  logic            out_load;
  logic [31:0]     digit_val;
  logic [SPW-1:0]  below;
  logic [AW-1:0]   below_idx;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [31:0]     mem_wd;
  alu_op_t         dec_op;
  alu_req_t        alu_req;
  alu_stat_t       alu_stat;
  logic [31:0]     alu_res;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign is_digit  = in_item.character inside {[CH_ZERO:CH_NINE]};
  assign is_op     = in_item.character inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
  assign any_flag  = ovf_r | und_r | dze_r;
  assign full      = (sp_r == SPW'(STACK_DEPTH));
  assign digit_val = {28'd0, 4'(in_item.character - CH_ZERO)};
  assign below     = sp_r - SPW'(2);
  assign below_idx = below[AW-1:0];
  assign push_ok   = in_acc && !in_item.command && !any_flag && is_digit && !full;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    case (in_item.character)
      CH_PLUS:  dec_op = ALU_ADD;
      CH_MINUS: dec_op = ALU_SUB;
      CH_STAR:  dec_op = ALU_MUL;
      default:  dec_op = ALU_DIV;
    endcase
  end

  assign mem_we = push_ok || ((state_r == S_WAIT) && alu_stat.done);
  assign mem_wa = push_ok ? sp_r[AW-1:0] : below_idx;
  assign mem_wd = push_ok ? digit_val : alu_res;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[below_idx];
  end

  assign alu_req.start = (state_r == S_EXEC);
  assign alu_req.op    = op_r;
  assign alu_req.a     = top_r;
  assign alu_req.b     = rd_r;

  rpn_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .stat   (alu_stat),
    .result (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      ovf_r       <= 1'b0;
      und_r       <= 1'b0;
      dze_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_OUT;
            if (in_item.command) begin
              sp_r     <= '0;
              ovf_r    <= 1'b0;
              und_r    <= 1'b0;
              dze_r    <= 1'b0;
              status_r <= ST_OK;
            end else if (any_flag) begin
              status_r <= ST_HALT;
            end else if (is_digit) begin
              if (full) begin
                ovf_r    <= 1'b1;
                status_r <= ST_OVER;
              end else begin
                top_r    <= digit_val;
                sp_r     <= sp_r + SPW'(1);
                status_r <= ST_OK;
              end
            end else if (is_op) begin
              if (sp_r < SPW'(2)) begin
                und_r    <= 1'b1;
                status_r <= ST_UNDER;
              end else if ((dec_op == ALU_DIV) && (top_r == 32'd0)) begin
                dze_r    <= 1'b1;
                status_r <= ST_DIVZ;
              end else begin
                op_r    <= dec_op;
                state_r <= S_EXEC;
              end
            end else begin
              status_r <= ST_REJECT;
            end
          end
        end
        S_EXEC: state_r <= S_WAIT;
        S_WAIT: begin
          if (alu_stat.done) begin
            top_r    <= alu_res;
            sp_r     <= sp_r - SPW'(1);
            status_r <= ST_OK;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_item_r.status    <= status_r;
            out_item_r.top_value <= (sp_r != '0) ? top_r : 32'd0;
            out_item_r.depth     <= 8'(sp_r);
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `RPN_ASSERT_ALWAYS(a_sp_range, sp_r <= SPW'(STACK_DEPTH), "stack pointer beyond depth")
  `RPN_ASSERT_IMP(a_ready_alu_idle, in_ready, !alu_stat.busy, "input ready while unit busy")
  `RPN_ASSERT_IMP(a_done_in_wait, alu_stat.done, state_r == S_WAIT, "unit done outside wait")
  `RPN_ASSERT_NEXT(a_halt_stable, in_acc && !in_item.command && any_flag, $stable(sp_r),
                   "halted item changed the stack")
  `RPN_ASSERT_IMP(a_op_depth, state_r == S_EXEC, sp_r >= SPW'(2), "operator with short stack")

endmodule

`default_nettype wire
